// File: hw/rtl/fnc_pkg.sv
// Shared types and constants of the frequency to note and cents converter.
`default_nettype none
package fnc_pkg;

  localparam int DATA_W         = 32;
  localparam int NOTE_COUNT     = 120;
  localparam int REF_INDEX      = 57;
  localparam logic [DATA_W-1:0] REF_PITCH_RST = 32'd28835840;

  localparam int SH_W           = $clog2(DATA_W);
  localparam int NORM_STEPS     = SH_W;
  localparam int NK_W           = $clog2(NORM_STEPS);
  localparam int LOG_FRAC       = 28;
  localparam int LOG_W          = SH_W + LOG_FRAC;
  localparam int CNT_W          = $clog2(LOG_FRAC);
  localparam int P_W            = 2 * DATA_W;

  localparam int CENTS_PER_OCT  = 1200;
  localparam int MUL_W          = 12;
  localparam int SCALED_W       = LOG_W + 1 + MUL_W;
  localparam int TOTAL_W        = SCALED_W - LOG_FRAC;

  localparam int CENT_BIAS      = 40000;
  localparam int RESID_LOW      = 49;
  localparam int CENTS_PER_NOTE = 100;
  localparam int U_W            = 17;
  localparam int DIV_SHIFT      = 24;
  localparam int DIV_MULT       = (2 ** DIV_SHIFT + CENTS_PER_NOTE - 1) / CENTS_PER_NOTE;
  localparam int MULT_W         = 18;
  localparam int QP_W           = U_W + MULT_W;
  localparam int Q_W            = QP_W - DIV_SHIFT;
  localparam int STEP_BIAS      = CENT_BIAS / CENTS_PER_NOTE;
  localparam int IDX_LOW        = STEP_BIAS - REF_INDEX;
  localparam int IDX_HIGH       = IDX_LOW + NOTE_COUNT;

  localparam int NOTE_W         = 7;
  localparam int CENTS_W        = 6;
  localparam int REM_W          = 7;
  localparam int OUT_DATA_W     = 16;
  localparam int MAX_CENTS      = 50;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQ0,
    ST_SQ,
    ST_REFDONE,
    ST_SCALE,
    ST_ROUND,
    ST_DIV,
    ST_RESULT
  } fnc_state_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_LOW  = 2'd1,
    STAT_HIGH = 2'd2
  } fnc_status_t;

  typedef struct packed {
    logic            cfg_wr;
    logic            load_in;
    logic            load_ref;
    logic            norm;
    logic [NK_W-1:0] norm_k;
    logic            sq_first;
    logic            sq_step;
    logic            store_ref;
    logic            scale;
    logic            round;
    logic            divide;
    logic            result;
  } fnc_cmd_t;

  typedef struct packed {
    logic out_busy;
  } fnc_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/fnc_ctrl.sv
// Sequencer of the converter: log2 passes, scaling, note split and result handoff.
`default_nettype none
module fnc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire fnc_pkg::fnc_sts_t sts,
  output fnc_pkg::fnc_cmd_t    cmd
);

  fnc_pkg::fnc_state_t            state_r, state_nxt;
  logic [fnc_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           tgt_ref_r, tgt_ref_nxt;
  logic                           ref_ok_r, ref_ok_nxt;
  logic                           in_fire;
  logic                           cfg_fire;

  assign cfg_ready = (state_r == fnc_pkg::ST_IDLE);
  assign in_tready = (state_r == fnc_pkg::ST_IDLE) && ref_ok_r && !cfg_valid;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= fnc_pkg::ST_IDLE;
      cnt_r     <= '0;
      tgt_ref_r <= 1'b0;
      ref_ok_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      tgt_ref_r <= tgt_ref_nxt;
      ref_ok_r  <= ref_ok_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    tgt_ref_nxt = tgt_ref_r;
    ref_ok_nxt  = ref_ok_r;
    unique case (state_r)
      fnc_pkg::ST_IDLE: begin
        if (cfg_fire) begin
          ref_ok_nxt = 1'b0;
        end else if (!ref_ok_r) begin
          state_nxt   = fnc_pkg::ST_NORM;
          cnt_nxt     = '0;
          tgt_ref_nxt = 1'b1;
        end else if (in_fire) begin
          state_nxt   = fnc_pkg::ST_NORM;
          cnt_nxt     = '0;
          tgt_ref_nxt = 1'b0;
        end
      end
      fnc_pkg::ST_NORM: begin
        if (cnt_r == fnc_pkg::CNT_W'(fnc_pkg::NORM_STEPS - 1)) begin
          state_nxt = fnc_pkg::ST_SQ0;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + fnc_pkg::CNT_W'(1);
        end
      end
      fnc_pkg::ST_SQ0: begin
        state_nxt = fnc_pkg::ST_SQ;
      end
      fnc_pkg::ST_SQ: begin
        if (cnt_r == fnc_pkg::CNT_W'(fnc_pkg::LOG_FRAC - 1)) begin
          state_nxt = tgt_ref_r ? fnc_pkg::ST_REFDONE : fnc_pkg::ST_SCALE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + fnc_pkg::CNT_W'(1);
        end
      end
      fnc_pkg::ST_REFDONE: begin
        ref_ok_nxt = 1'b1;
        state_nxt  = fnc_pkg::ST_IDLE;
      end
      fnc_pkg::ST_SCALE: state_nxt = fnc_pkg::ST_ROUND;
      fnc_pkg::ST_ROUND: state_nxt = fnc_pkg::ST_DIV;
      fnc_pkg::ST_DIV:   state_nxt = fnc_pkg::ST_RESULT;
      fnc_pkg::ST_RESULT: begin
        if (!sts.out_busy) begin
          state_nxt = fnc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fnc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.cfg_wr = cfg_fire;
    cmd.norm_k = cnt_r[fnc_pkg::NK_W-1:0];
    unique case (state_r)
      fnc_pkg::ST_IDLE: begin
        cmd.load_ref = !cfg_fire && !ref_ok_r;
        cmd.load_in  = in_fire;
      end
      fnc_pkg::ST_NORM:    cmd.norm      = 1'b1;
      fnc_pkg::ST_SQ0:     cmd.sq_first  = 1'b1;
      fnc_pkg::ST_SQ:      cmd.sq_step   = 1'b1;
      fnc_pkg::ST_REFDONE: cmd.store_ref = 1'b1;
      fnc_pkg::ST_SCALE:   cmd.scale     = 1'b1;
      fnc_pkg::ST_ROUND:   cmd.round     = 1'b1;
      fnc_pkg::ST_DIV:     cmd.divide    = 1'b1;
      fnc_pkg::ST_RESULT:  cmd.result    = !sts.out_busy;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> !in_tready)
    else $error("input accepted right after a reference pitch write");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted while an item is in progress");

  a_result_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |-> !sts.out_busy && !tgt_ref_r)
    else $error("result issued over a pending beat");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/fnc_dpath.sv
// Datapath: shared normalize and squaring log2 unit, cent scaling, note split, output register.
`default_nettype none
module fnc_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire fnc_pkg::fnc_cmd_t               cmd,
  output fnc_pkg::fnc_sts_t                    sts,
  input  wire logic [fnc_pkg::DATA_W-1:0]      in_tdata,
  input  wire logic [fnc_pkg::DATA_W-1:0]      cfg_data,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [fnc_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [1:0]                           out_tuser
);

  logic [fnc_pkg::DATA_W-1:0]          ref_pitch_r;
  logic [fnc_pkg::DATA_W-1:0]          x_r;
  logic [fnc_pkg::SH_W-1:0]            sh_r;
  logic                                zero_r;
  logic [fnc_pkg::P_W-1:0]             p_r;
  logic [fnc_pkg::LOG_FRAC-1:0]        frac_r;
  logic [fnc_pkg::LOG_W-1:0]           log_ref_r;
  logic signed [fnc_pkg::SCALED_W-1:0] scaled_r;
  logic [fnc_pkg::U_W-1:0]             u_r;
  logic [fnc_pkg::QP_W-1:0]            qp_r;

  logic                                out_valid_r;
  logic [fnc_pkg::NOTE_W-1:0]          out_note_r;
  logic [fnc_pkg::CENTS_W-1:0]         out_cents_r;
  logic                                out_flat_r;
  fnc_pkg::fnc_status_t                out_stat_r;

  logic [fnc_pkg::SH_W-1:0]            amt;
  logic [fnc_pkg::DATA_W-1:0]          top_mask;
  logic                                top_zero;
  logic [fnc_pkg::DATA_W:0]            sq_t;
  logic [fnc_pkg::DATA_W-1:0]          sq_norm;
  logic [fnc_pkg::DATA_W-1:0]          sq_in;
  logic [fnc_pkg::LOG_W-1:0]           log_cur;
  logic signed [fnc_pkg::LOG_W:0]      diff;
  logic signed [fnc_pkg::SCALED_W-1:0] rnd;
  logic signed [fnc_pkg::TOTAL_W-1:0]  total;
  logic signed [fnc_pkg::TOTAL_W-1:0]  u_sum;
  logic [fnc_pkg::Q_W-1:0]             q;
  logic [fnc_pkg::U_W-1:0]             prod;
  logic [fnc_pkg::U_W-1:0]             rem_full;
  logic [fnc_pkg::REM_W-1:0]           rem;

  logic [fnc_pkg::NOTE_W-1:0]          res_note;
  logic [fnc_pkg::CENTS_W-1:0]         res_cents;
  logic                                res_flat;
  fnc_pkg::fnc_status_t                res_stat;

  assign amt      = fnc_pkg::SH_W'(fnc_pkg::DATA_W / 2) >> cmd.norm_k;
  assign top_mask = ~({fnc_pkg::DATA_W{1'b1}} >> amt);
  assign top_zero = ((x_r & top_mask) == '0);

  assign sq_t     = p_r[fnc_pkg::P_W-1:fnc_pkg::DATA_W-1];
  assign sq_norm  = sq_t[fnc_pkg::DATA_W] ? sq_t[fnc_pkg::DATA_W:1]
                                          : sq_t[fnc_pkg::DATA_W-1:0];
  assign sq_in    = cmd.sq_first ? x_r : sq_norm;

  assign log_cur  = {fnc_pkg::SH_W'(fnc_pkg::DATA_W - 1) - sh_r, frac_r};
  assign diff     = $signed({1'b0, log_cur}) - $signed({1'b0, log_ref_r});

  assign rnd      = scaled_r + (fnc_pkg::SCALED_W'(1) << (fnc_pkg::LOG_FRAC - 1));
  assign total    = rnd[fnc_pkg::SCALED_W-1:fnc_pkg::LOG_FRAC];
  assign u_sum    = total
                  + $signed(fnc_pkg::TOTAL_W'(fnc_pkg::CENT_BIAS + fnc_pkg::RESID_LOW));

  assign q        = qp_r[fnc_pkg::QP_W-1:fnc_pkg::DIV_SHIFT];
  assign prod     = fnc_pkg::U_W'(q) * fnc_pkg::U_W'(fnc_pkg::CENTS_PER_NOTE);
  assign rem_full = u_r - prod;
  assign rem      = rem_full[fnc_pkg::REM_W-1:0];

  always_comb begin
    res_note  = '0;
    res_cents = '0;
    res_flat  = 1'b0;
    res_stat  = fnc_pkg::STAT_OK;
    if (zero_r) begin
      res_stat = fnc_pkg::STAT_LOW;
    end else if (ref_pitch_r == '0) begin
      res_stat = fnc_pkg::STAT_HIGH;
    end else if (q < fnc_pkg::Q_W'(fnc_pkg::IDX_LOW)) begin
      res_stat = fnc_pkg::STAT_LOW;
    end else if (q >= fnc_pkg::Q_W'(fnc_pkg::IDX_HIGH)) begin
      res_stat = fnc_pkg::STAT_HIGH;
    end else begin
      res_note = fnc_pkg::NOTE_W'(q - fnc_pkg::Q_W'(fnc_pkg::IDX_LOW));
      if (rem < fnc_pkg::REM_W'(fnc_pkg::RESID_LOW)) begin
        res_flat  = 1'b1;
        res_cents = fnc_pkg::CENTS_W'(fnc_pkg::REM_W'(fnc_pkg::RESID_LOW) - rem);
      end else begin
        res_cents = fnc_pkg::CENTS_W'(rem - fnc_pkg::REM_W'(fnc_pkg::RESID_LOW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_pitch_r <= fnc_pkg::REF_PITCH_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cfg_wr) begin
        ref_pitch_r <= cfg_data;
      end
      if (cmd.result) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r    <= in_tdata;
      sh_r   <= '0;
      zero_r <= (in_tdata == '0);
    end else if (cmd.load_ref) begin
      x_r  <= ref_pitch_r;
      sh_r <= '0;
    end else if (cmd.norm && top_zero) begin
      x_r  <= x_r << amt;
      sh_r <= sh_r + amt;
    end
    if (cmd.sq_first || cmd.sq_step) begin
      p_r <= sq_in * sq_in;
    end
    if (cmd.sq_first) begin
      frac_r <= '0;
    end else if (cmd.sq_step) begin
      frac_r <= {frac_r[fnc_pkg::LOG_FRAC-2:0], sq_t[fnc_pkg::DATA_W]};
    end
    if (cmd.store_ref) begin
      log_ref_r <= log_cur;
    end
    if (cmd.scale) begin
      scaled_r <= diff * $signed(fnc_pkg::MUL_W'(fnc_pkg::CENTS_PER_OCT));
    end
    if (cmd.round) begin
      u_r <= u_sum[fnc_pkg::U_W-1:0];
    end
    if (cmd.divide) begin
      qp_r <= fnc_pkg::QP_W'(u_r) * fnc_pkg::QP_W'(fnc_pkg::DIV_MULT);
    end
    if (cmd.result) begin
      out_note_r  <= res_note;
      out_cents_r <= res_cents;
      out_flat_r  <= res_flat;
      out_stat_r  <= res_stat;
    end
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = fnc_pkg::OUT_DATA_W'({out_flat_r, out_cents_r, out_note_r});
  assign out_tuser    = out_stat_r;

`ifndef NO_ASSERTIONS
  a_flagged_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != fnc_pkg::STAT_OK) |-> (out_tdata == '0))
    else $error("flagged beat carries a note or cents");

  a_cents_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == fnc_pkg::STAT_OK) |->
      (out_tdata[fnc_pkg::NOTE_W+fnc_pkg::CENTS_W-1:fnc_pkg::NOTE_W]
        <= fnc_pkg::CENTS_W'(fnc_pkg::MAX_CENTS)))
    else $error("cent offset beyond half a semitone");

  a_note_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == fnc_pkg::STAT_OK) |->
      ({1'b0, out_tdata[fnc_pkg::NOTE_W-1:0]} < (fnc_pkg::NOTE_W+1)'(fnc_pkg::NOTE_COUNT)))
    else $error("note index past the last note");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/frequency_to_note_cents_core.sv
// Top level: frequency to nearest note index and cent offset, stream ports.
// Per input beat: 5 normalize steps and 28 squaring steps, then the scale, round, divide and result states.
// One item at a time: in_tready stays low until the result enters the output register, which waits on out_tready.
// The reference log2 is recomputed after reset and after each cfg write, with
// in_tready low meanwhile. Synchronous active-low reset: control cleared, pitch 440 Hz.
`default_nettype none
module frequency_to_note_cents_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] frequency_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [6:0] note_index, [12:7] cents_offset, [13] is_flat
  output logic [1:0]       out_tuser,  // [1:0] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data    // reference_pitch
);

  fnc_pkg::fnc_cmd_t cmd;
  fnc_pkg::fnc_sts_t sts;

  fnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fnc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// File: bench/frequency_to_note_cents_core_tb.sv
// Self-checking testbench for the frequency to note and cents converter.
module frequency_to_note_cents_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LOG_FRAC_BITS  = 28;
  localparam longint      CENT_OFFSET    = 40000;
  localparam longint      OCTAVE_CENTS   = 1200;
  localparam longint      NOTE_CENTS     = 100;
  localparam longint      LOW_RESID      = 49;
  localparam longint      A4_INDEX       = 57;
  localparam longint      NOTES          = 120;
  localparam logic [31:0] PITCH_440      = 32'd28835840;
  localparam logic [31:0] PITCH_432      = 32'd28311552;
  localparam logic [31:0] PITCH_MIN      = 32'h0001_0000;
  localparam logic [31:0] PITCH_MAX      = 32'hFFFF_FFFF;
  localparam int          PHASES         = 6;
  localparam int          PHASE_ITEMS    = 325;
  localparam int          PRESSURE_PHASE = 4;
  localparam int          SETTLE_CYCLES  = 60;
  localparam int          CYCLE_LIMIT    = 2_000_000;

  typedef struct packed {
    logic [6:0]           note;
    logic [5:0]           cents;
    logic                 flat;
    fnc_pkg::fnc_status_t status;
  } note_result_t;

  typedef struct packed {
    logic [31:0]  freq;
    logic         known;
    note_result_t want;
  } freq_row_t;

  localparam freq_row_t DIRECTED_ROWS [24] = '{
    '{32'd0,          1'b1, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_LOW}},
    '{32'd1,          1'b1, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_LOW}},
    '{32'h0001_0000,  1'b1, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_LOW}},
    '{32'hFFFF_FFFF,  1'b1, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_HIGH}},
    '{32'h8000_0000,  1'b1, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_HIGH}},
    '{32'd28835840,   1'b1, '{7'd57,  6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd57671680,   1'b1, '{7'd69,  6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd14417920,   1'b1, '{7'd45,  6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd7208960,    1'b1, '{7'd33,  6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd1802240,    1'b1, '{7'd9,   6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd922746880,  1'b1, '{7'd117, 6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd1071514,    1'b0, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd1035469,    1'b0, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd1042022,    1'b0, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd1065615360, 1'b0, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd1066926080, 1'b0, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd29680596,   1'b0, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd29680796,   1'b0, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd29680996,   1'b0, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd28030000,   1'b0, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'd30550000,   1'b0, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'h5555_5555,  1'b0, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'hAAAA_AAAA,  1'b0, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_OK}},
    '{32'h0000_FFFF,  1'b0, '{7'd0,   6'd0, 1'b0, fnc_pkg::STAT_OK}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  note_result_t pending_notes [$];
  logic [31:0]  ref_pitch;
  int           sender_idle_pct;
  int           receiver_stall_pct;
  int           mismatch_count = 0;
  int           cycle_count;

  frequency_to_note_cents_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("frequency_to_note_cents_core_tb failed");
        $finish;
      end
    end
  end

  // log2 with the leading-one position as integer part, 28 fraction bits by squaring
  function automatic longint log2_q28(input logic [31:0] x);
    int              lead;
    longint unsigned mant;
    longint unsigned frac;
    lead = 0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        lead = i;
      end
    end
    mant = {32'd0, x} << (31 - lead);
    frac = 0;
    for (int i = 0; i < LOG_FRAC_BITS; i++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        mant = mant >> 1;
      end
    end
    return longint'((64'(lead) << LOG_FRAC_BITS) | frac);
  endfunction

  function automatic note_result_t nearest_note(input logic [31:0] freq,
                                                input logic [31:0] pitch);
    note_result_t    res;
    longint          scaled;
    longint unsigned biased;
    longint          total;
    longint          step;
    longint          resid;
    longint          idx;
    res = '{7'd0, 6'd0, 1'b0, fnc_pkg::STAT_OK};
    if (freq == 32'd0) begin
      res.status = fnc_pkg::STAT_LOW;
      return res;
    end
    if (pitch == 32'd0) begin
      res.status = fnc_pkg::STAT_HIGH;
      return res;
    end
    scaled = (log2_q28(freq) - log2_q28(pitch)) * OCTAVE_CENTS;
    biased = $unsigned(scaled + (CENT_OFFSET << LOG_FRAC_BITS));
    biased = biased + (64'd1 << (LOG_FRAC_BITS - 1));
    total  = longint'(biased >> LOG_FRAC_BITS) - CENT_OFFSET;
    step   = (total + LOW_RESID + CENT_OFFSET) / NOTE_CENTS - CENT_OFFSET / NOTE_CENTS;
    resid  = total - NOTE_CENTS * step;
    idx    = A4_INDEX + step;
    if (idx < 0) begin
      res.status = fnc_pkg::STAT_LOW;
    end else if (idx >= NOTES) begin
      res.status = fnc_pkg::STAT_HIGH;
    end else begin
      res.note = 7'(idx);
      if (resid < 0) begin
        res.cents = 6'(-resid);
        res.flat  = 1'b1;
      end else begin
        res.cents = 6'(resid);
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] random_freq(input logic [31:0] pitch);
    int          sel;
    int          top;
    int          lead;
    logic [31:0] val;
    sel = $urandom_range(99);
    if (sel < 15) begin
      return $urandom;
    end
    if (sel < 22) begin
      return $urandom_range(255);
    end
    top = 31;
    while (top > 0 && !pitch[top]) top--;
    lead = $urandom_range((top + 6 > 31) ? 31 : top + 6, (top < 6) ? 0 : top - 6);
    val  = $urandom;
    return (32'd1 << lead) | (val & ((32'd1 << lead) - 32'd1));
  endfunction

  task automatic send_freq(input logic [31:0] freq, input logic known,
                           input note_result_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= freq;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_notes.push_back(known ? want : nearest_note(freq, ref_pitch));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pitch(input logic [31:0] pitch);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= pitch;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ref_pitch = pitch;
  endtask

  always @(posedge clk) begin : check_results
    note_result_t got;
    note_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.note   = out_tdata[6:0];
      got.cents  = out_tdata[12:7];
      got.flat   = out_tdata[13];
      got.status = fnc_pkg::fnc_status_t'(out_tuser);
      if (pending_notes.size() == 0) begin
        $error("unexpected result beat: note_index %0d status %0d", got.note, got.status);
        mismatch_count++;
      end else begin
        want = pending_notes.pop_front();
        if (got.note !== want.note) begin
          $error("note_index expected %0d got %0d", want.note, got.note);
          mismatch_count++;
        end
        if (got.cents !== want.cents) begin
          $error("cents_offset expected %0d got %0d", want.cents, got.cents);
          mismatch_count++;
        end
        if (got.flat !== want.flat) begin
          $error("is_flat expected %0d got %0d", want.flat, got.flat);
          mismatch_count++;
        end
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status);
          mismatch_count++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  initial begin
    logic [31:0] pitch;
    rst_n              = 1'b0;
    in_tvalid          = 1'b0;
    in_tdata           = 32'd0;
    cfg_valid          = 1'b0;
    cfg_data           = 32'd0;
    ref_pitch          = PITCH_440;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      send_freq(DIRECTED_ROWS[i].freq, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: pitch = PITCH_MIN;
        1: pitch = PITCH_MAX;
        2: pitch = PITCH_432;
        3: begin
          pitch = $urandom;
          if (pitch < PITCH_MIN) begin
            pitch = pitch | PITCH_MIN;
          end
        end
        4: pitch = PITCH_440;
        default: pitch = PITCH_MIN + 32'd1;
      endcase
      write_pitch(pitch);
      case (p % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 87;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 87;
        end
        default: begin
          sender_idle_pct    = 29;
          receiver_stall_pct = 29;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == PRESSURE_PHASE && n % 50 == 49) begin
          drain_results();
        end
        send_freq(random_freq(ref_pitch), 1'b0, '{7'd0, 6'd0, 1'b0, fnc_pkg::STAT_OK});
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("frequency_to_note_cents_core_tb passed");
    end else begin
      $display("frequency_to_note_cents_core_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/fnc_pkg.sv
hw/rtl/fnc_ctrl.sv
hw/rtl/fnc_dpath.sv
hw/rtl/frequency_to_note_cents_core.sv
bench/frequency_to_note_cents_core_tb.sv
